// ===== sv/rgrc_pkg.sv =====
`default_nettype none
package rgrc_pkg;
  localparam int TimeW  = 48;
  localparam int RttW   = 32;
  localparam int RateW  = 25;
  localparam int Q16W   = 17;
  localparam int StageW = 5;
  localparam int DiffW  = 34;
  localparam int GradW  = 24;
  localparam int DvdW   = 50;
  localparam int MulAW  = 35;
  localparam int MulBW  = 18;
  localparam int MulPW  = MulAW + MulBW;

  localparam logic [Q16W-1:0]  OneQ16 = 17'd65536;
  localparam logic [RateW-1:0] OneQ24 = 25'd16777216;

  typedef enum logic [2:0] {
    REG_EWMA  = 3'd0,
    REG_BETA  = 3'd1,
    REG_STEP  = 3'd2,
    REG_MINR  = 3'd3,
    REG_STAGE = 3'd4,
    REG_BASE  = 3'd5,
    REG_LOW   = 3'd6,
    REG_HIGH  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic [DvdW-1:0] dividend;
    logic [RttW-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ===== sv/rgrc_div.sv =====
`default_nettype none
module rgrc_div
  import rgrc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire div_req_t       req,
  output logic                done,
  output logic [DvdW-1:0]     quotient
);
  localparam int CntW = $clog2(DvdW + 1);

  logic [RttW-1:0] rem;
  logic [RttW-1:0] dsr;
  logic [DvdW-1:0] dvd;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [RttW:0]   shifted;
  logic            fits;

  assign shifted = {rem, dvd[DvdW-1]};
  assign fits    = shifted >= {1'b0, dsr};

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DvdW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      dsr      <= req.divisor;
      dvd      <= req.dividend;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? RttW'(shifted - {1'b0, dsr}) : shifted[RttW-1:0];
      dvd      <= {dvd[DvdW-2:0], 1'b0};
      quotient <= {quotient[DvdW-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ===== sv/rgrc_mul.sv =====
`default_nettype none
module rgrc_mul
  import rgrc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [MulAW-1:0] a,
  input  wire logic signed [MulBW-1:0] b,
  output logic signed [MulPW-1:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

// ===== sv/rtt_gradient_rate_control.sv =====
`default_nettype none
// channel   dir  fields (low bit up)
// s_axis    in   tdata: sent_time[47:0], arrival_time[95:48]
// m_axis    out  tdata: rate_ratio[24:0], measured_rtt[56:25], zero pad
// apb       in   registers at 4*i, i = 0..7
// Each 50-bit division runs one bit a cycle on the shared divider, and each
// product is registered in the shared multiplier.
// Synchronous reset restores registers and state; no clearing pass.
// s_axis_tready is high only while idle; a stalled result holds in place.
module rtt_gradient_rate_control
  import rgrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // sent_time, arrival_time
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // rate_ratio, measured_rtt
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_EW1    = 15'b000000000000010,
    S_EW2    = 15'b000000000000100,
    S_EW3    = 15'b000000000001000,
    S_GDIV   = 15'b000000000010000,
    S_HI1    = 15'b000000000100000,
    S_HI2    = 15'b000000001000000,
    S_HI3    = 15'b000000010000000,
    S_GD1    = 15'b000000100000000,
    S_GD2    = 15'b000001000000000,
    S_SCALE  = 15'b000010000000000,
    S_SCL2   = 15'b000100000000000,
    S_HAI    = 15'b001000000000000,
    S_HAI2   = 15'b010000000000000,
    S_HAIADD = 15'b100000000000000
  } state_t;

  logic [Q16W-1:0]   ewma_weight, decrease_factor;
  logic [RateW-1:0]  additive_step, min_rate;
  logic [StageW-1:0] max_stage;
  logic [RttW-1:0]   base_rtt, low_threshold, high_threshold;

  state_t state;
  logic              clamp_pend, out_valid;
  logic [RttW-1:0]   rtt, last_rtt;
  logic              have_last;
  logic signed [DiffW-1:0] sd;
  logic [StageW-1:0] stage;
  logic [RateW-1:0]  rate;
  logic [30:0]       rate_tmp;
  logic signed [MulPW-1:0] acc;
  logic signed [GradW-1:0] grad;
  logic [Q16W-1:0]   keep;

  logic [Q16W-1:0]   a_eff, beta_eff;
  logic [StageW-1:0] n_eff;
  logic [RttW-1:0]   div_eff;
  logic [RateW-1:0]  minr_eff;

  logic signed [MulAW-1:0] ma;
  logic signed [MulBW-1:0] mb;
  logic signed [MulPW-1:0] mp;
  div_req_t          dreq;
  logic              ddone;
  logic [DvdW-1:0]   dq;

  logic [TimeW-1:0]  sent, arrv, tdiff;
  logic [RttW-1:0]   rtt_in;
  logic signed [MulPW:0] sum;
  logic signed [DiffW-1:0] sd_new;
  logic [DiffW-1:0]  sd_mag;
  logic signed [GradW-1:0] grad_c;
  logic              grad_pos;
  logic [StageW:0]   stage_inc;
  logic [30:0]       clamped;
  logic [36:0]       m_raw;
  logic              wr;

  assign pready   = 1'b1;
  assign wr       = psel & penable & pwrite;
  assign a_eff    = ewma_weight > OneQ16 ? OneQ16 : ewma_weight;
  assign beta_eff = decrease_factor > OneQ16 ? OneQ16 : decrease_factor;
  assign n_eff    = max_stage == '0 ? StageW'(1) : max_stage;
  assign div_eff  = base_rtt == '0 ? RttW'(1) : base_rtt;
  assign minr_eff = min_rate > OneQ24 ? OneQ24 : min_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_weight     <= 17'd57344;
      decrease_factor <= 17'd52429;
      additive_step   <= 25'd8389;
      min_rate        <= 25'd16777;
      max_stage       <= 5'd5;
      base_rtt        <= 32'd2000000;
      low_threshold   <= 32'd5000000;
      high_threshold  <= 32'd50000000;
    end else if (wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_EWMA:  ewma_weight     <= pwdata[Q16W-1:0];
        REG_BETA:  decrease_factor <= pwdata[Q16W-1:0];
        REG_STEP:  additive_step   <= pwdata[RateW-1:0];
        REG_MINR:  min_rate        <= pwdata[RateW-1:0];
        REG_STAGE: max_stage       <= pwdata[StageW-1:0];
        REG_BASE:  base_rtt        <= pwdata;
        REG_LOW:   low_threshold   <= pwdata;
        REG_HIGH:  high_threshold  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_EWMA:  prdata = 32'(ewma_weight);
      REG_BETA:  prdata = 32'(decrease_factor);
      REG_STEP:  prdata = 32'(additive_step);
      REG_MINR:  prdata = 32'(min_rate);
      REG_STAGE: prdata = 32'(max_stage);
      REG_BASE:  prdata = base_rtt;
      REG_LOW:   prdata = low_threshold;
      REG_HIGH:  prdata = high_threshold;
      default:   prdata = '0;
    endcase
  end

  assign sent   = s_axis_tdata[47:0];
  assign arrv   = s_axis_tdata[95:48];
  assign tdiff  = arrv - sent;
  assign rtt_in = arrv <= sent ? '0 :
                  (tdiff[47:32] != '0 ? '1 : tdiff[31:0]);

  assign sum    = (MulPW+1)'(acc) + (MulPW+1)'(mp) + (MulPW+1)'(32768);
  assign sd_new = sum[DiffW+15:16];
  assign sd_mag = sd_new[DiffW-1] ? DiffW'(-sd_new) : DiffW'(sd_new);

  // signed quotient, truncated toward zero, saturated to Q8.16
  always_comb begin
    if (sd[DiffW-1]) begin
      grad_c = dq > DvdW'(24'h800000) ? -24'sd8388608 : -$signed(dq[GradW-1:0]);
    end else begin
      grad_c = dq > DvdW'(24'h7fffff) ? 24'sd8388607 : $signed(dq[GradW-1:0]);
    end
  end
  assign grad_pos  = !sd[DiffW-1] && dq != '0;
  assign stage_inc = n_eff > StageW'(1) ? {1'b0, stage} + 1'b1 : {1'b0, stage};
  assign m_raw     = mp[52:16];

  always_comb begin
    clamped = rate_tmp > 31'(OneQ24) ? 31'(OneQ24) : rate_tmp;
    if (clamped < 31'(minr_eff)) clamped = 31'(minr_eff);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_EW1: begin
        ma = MulAW'($signed({1'b0, rtt}) - $signed({1'b0, last_rtt}));
        mb = $signed({1'b0, a_eff});
      end
      S_EW2: begin
        ma = MulAW'(sd);
        mb = $signed({1'b0, OneQ16 - a_eff});
      end
      S_HI1: begin
        ma = $signed({3'b0, high_threshold});
        mb = $signed({1'b0, beta_eff});
      end
      S_GD1: begin
        ma = MulAW'(grad);
        mb = $signed({1'b0, beta_eff});
      end
      S_SCALE: begin
        ma = $signed({10'b0, rate});
        mb = $signed({1'b0, keep});
      end
      S_HAI: begin
        ma = $signed({10'b0, additive_step});
        mb = $signed({13'b0, n_eff});
      end
      default: ;
    endcase
  end

  always_comb begin
    dreq = '0;
    if (state == S_EW3) begin
      dreq.start    = 1'b1;
      dreq.dividend = {sd_mag, 16'b0};
      dreq.divisor  = div_eff;
    end else if (state == S_HI2) begin
      dreq.start    = 1'b1;
      dreq.dividend = DvdW'(mp);
      dreq.divisor  = rtt;
    end
  end

  rgrc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  rgrc_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clamp_pend <= 1'b0;
      out_valid  <= 1'b0;
      have_last  <= 1'b0;
      last_rtt   <= '0;
      sd         <= '0;
      stage      <= StageW'(1);
      rate       <= OneQ24;
      rtt        <= '0;
    end else begin
      if (clamp_pend) begin
        rate       <= clamped[RateW-1:0];
        clamp_pend <= 1'b0;
        out_valid  <= 1'b1;
      end
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
        state     <= S_IDLE;
      end
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          rtt       <= rtt_in;
          have_last <= 1'b1;
          if (have_last) begin
            state <= S_EW1;
          end else begin
            last_rtt  <= rtt_in;
            out_valid <= 1'b1;
            state     <= S_HAI2;
          end
        end
        // the difference is taken this cycle; advance the previous RTT after it
        S_EW1: begin
          last_rtt <= rtt;
          state    <= S_EW2;
        end
        S_EW2: begin
          acc   <= mp;
          state <= S_EW3;
        end
        S_EW3: begin
          sd    <= sd_new;
          state <= S_GDIV;
        end
        S_GDIV: if (ddone) begin
          grad <= grad_c;
          if (rtt < low_threshold) begin
            rate_tmp <= 31'(rate) + 31'(additive_step);
            clamp_pend <= 1'b1;
            state <= S_HAI2;
          end else if (rtt > high_threshold) begin
            state <= S_HI1;
          end else if (!grad_pos) begin
            if (stage_inc > {1'b0, n_eff}) begin
              stage <= n_eff;
              state <= S_HAI;
            end else begin
              stage      <= stage_inc[StageW-1:0];
              rate_tmp   <= 31'(rate) + 31'(additive_step);
              clamp_pend <= 1'b1;
              state      <= S_HAI2;
            end
          end else begin
            stage <= StageW'(1);
            state <= S_GD1;
          end
        end
        S_HI1: state <= S_HI2;
        S_HI2: state <= S_HI3;
        S_HI3: if (ddone) begin
          keep  <= dq > DvdW'(OneQ16) ? '0 : Q16W'(OneQ16 - dq[Q16W-1:0]);
          state <= S_SCALE;
        end
        S_GD1: state <= S_GD2;
        S_GD2: begin
          keep  <= m_raw > 37'(OneQ16) ? '0 : Q16W'(OneQ16 - m_raw[Q16W-1:0]);
          state <= S_SCALE;
        end
        S_SCALE: state <= S_SCL2;
        S_SCL2: begin
          rate_tmp   <= 31'(mp[52:16]);
          clamp_pend <= 1'b1;
          state      <= S_HAI2;
        end
        // wait here while the stage-limit product is registered
        S_HAI: state <= S_HAIADD;
        S_HAIADD: begin
          rate_tmp   <= 31'(rate) + 31'(mp);
          clamp_pend <= 1'b1;
          state      <= S_HAI2;
        end
        // wait for the result transfer
        S_HAI2: ;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, rtt, rate};
endmodule
`default_nettype wire
